// ===== sv/qjt_pkg.sv =====
package qjt_pkg;

    typedef struct packed {
        logic               opcode;
        logic [2:0]         joint_index;
        logic signed [31:0] start_position;
        logic signed [31:0] end_position;
        logic [31:0]        move_duration;
        logic [31:0]        sample_time;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         out_joint;
        logic signed [31:0] position;
        logic signed [31:0] velocity;
        logic signed [31:0] acceleration;
        logic [1:0]         status;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic signed [31:0] p0;
        logic signed [47:0] p3;
        logic signed [47:0] p4;
        logic signed [47:0] p5;
    } t_coef;

    typedef struct packed {
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
    } t_eval_res;

    localparam int COEF_W = $bits(t_coef);

    localparam logic OP_PLAN   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] ST_SAMPLE   = 2'd0;
    localparam logic [1:0] ST_PLAN_OK  = 2'd1;
    localparam logic [1:0] ST_PLAN_REJ = 2'd2;

    localparam logic signed [63:0] HCAP = 64'sh4000_0000_0000_0000;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PDIV,
        S_PWR,
        S_POUT,
        S_RD,
        S_LD,
        S_EVAL,
        S_OUT
    } t_state;

endpackage

// ===== sv/qjt_ram.sv =====
module qjt_ram #(
    parameter int WIDTH = 176,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// ===== sv/qjt_div.sv =====
module qjt_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [32:0]        i_mag,
    input  logic               i_neg,
    input  logic [31:0]        i_dur,
    output logic               o_done,
    output logic signed [47:0] o_p3,
    output logic signed [47:0] o_p4,
    output logic signed [47:0] o_p5
);
    import qjt_pkg::*;

    logic         r_busy;
    logic [1:0]   r_ci;
    logic [2:0]   r_dcnt;
    logic [6:0]   r_bit;
    logic [127:0] r_num;
    logic [32:0]  r_rem;
    logic [32:0]  r_mag;
    logic         r_neg;
    logic [31:0]  r_dur;

    logic [32:0]  rem2;
    logic         ge;
    logic [127:0] n_num;
    logic [32:0]  n_rem;
    logic [46:0]  qmag;
    logic signed [47:0] coef;
    logic [2:0]   divs;

    // scaled numerator c*|d|*2^s for coefficient ci
    function automatic logic [127:0] f_num(input logic [1:0] ci, input logic [32:0] mag);
        logic [36:0]  prod;
        logic [127:0] wide;
        logic [127:0] res;
        begin
            case (ci)
                2'd0:    prod = {4'd0, mag} * 37'd10;
                2'd1:    prod = {4'd0, mag} * 37'd15;
                default: prod = {4'd0, mag} * 37'd6;
            endcase
            wide = {91'd0, prod};
            case (ci)
                2'd0:    res = wide << 56;
                2'd1:    res = wide << 72;
                default: res = wide << 88;
            endcase
            return res;
        end
    endfunction

    always_comb begin
        rem2  = {r_rem[31:0], r_num[127]};
        ge    = rem2 >= {1'b0, r_dur};
        n_rem = ge ? rem2 - {1'b0, r_dur} : rem2;
        n_num = {r_num[126:0], ge};
        qmag  = (|n_num[127:47]) ? 47'h7FFF_FFFF_FFFF : n_num[46:0];
        coef  = ((r_ci == 2'd1) ? !r_neg : r_neg) ? -$signed({1'b0, qmag})
                                                   : $signed({1'b0, qmag});
        case (r_ci)
            2'd0:    divs = 3'd3;
            2'd1:    divs = 3'd4;
            default: divs = 3'd5;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_bit == 7'd127)
                   && (r_dcnt == divs - 3'd1) && (r_ci == 2'd2);
            if (i_start) begin
                r_busy <= 1'b1;
                r_ci   <= 2'd0;
                r_dcnt <= 3'd0;
                r_bit  <= 7'd0;
                r_rem  <= 33'd0;
                r_num  <= f_num(2'd0, i_mag);
                r_mag  <= i_mag;
                r_neg  <= i_neg;
                r_dur  <= i_dur;
            end else if (r_busy) begin
                r_bit <= r_bit + 7'd1;
                if (r_bit != 7'd127) begin
                    r_num <= n_num;
                    r_rem <= n_rem;
                end else begin
                    r_rem <= 33'd0;
                    if (r_dcnt == divs - 3'd1) begin
                        case (r_ci)
                            2'd0:    o_p3 <= coef;
                            2'd1:    o_p4 <= coef;
                            default: o_p5 <= coef;
                        endcase
                        r_dcnt <= 3'd0;
                        if (r_ci == 2'd2) begin
                            r_busy <= 1'b0;
                        end else begin
                            r_ci  <= r_ci + 2'd1;
                            r_num <= f_num(r_ci + 2'd1, r_mag);
                        end
                    end else begin
                        r_num  <= n_num;
                        r_dcnt <= r_dcnt + 3'd1;
                    end
                end
            end
        end
    end
endmodule

// ===== sv/qjt_eval.sv =====
module qjt_eval (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  qjt_pkg::t_coef    i_coef,
    input  logic [31:0]       i_time,
    output logic              o_done,
    output qjt_pkg::t_eval_res o_res
);
    import qjt_pkg::*;

    logic               r_busy;
    logic [1:0]         r_ph;
    logic [3:0]         r_k;
    logic signed [63:0] r_h;
    logic [63:0]        r_lo;
    logic [63:0]        r_prod;
    t_coef              r_c;
    logic [31:0]        r_t;

    logic [63:0]        ua;
    logic [31:0]        mop;
    logic [63:0]        prod;
    logic [63:0]        s;
    logic signed [63:0] mr;
    logic signed [63:0] mt;
    logic signed [63:0] addend;
    logic signed [63:0] sum;
    logic signed [63:0] clamped;
    logic signed [63:0] p3w;
    logic signed [63:0] p4w;
    logic signed [63:0] p5w;

    // Q40.24 to Q16.16 toward zero, plus base, saturated
    function automatic logic signed [31:0] f_q16(input logic signed [63:0] h,
                                                 input logic signed [31:0] base);
        logic signed [63:0] v;
        begin
            v = h[63] ? -$signed((-h) >>> 8) : (h >>> 8);
            v = v + {{32{base[31]}}, base};
            if (v > 64'sh7FFF_FFFF) begin
                v = 64'sh7FFF_FFFF;
            end else if (v < -64'sh8000_0000) begin
                v = -64'sh8000_0000;
            end
            return v[31:0];
        end
    endfunction

    always_comb begin
        p3w  = {{16{r_c.p3[47]}}, r_c.p3};
        p4w  = {{16{r_c.p4[47]}}, r_c.p4};
        p5w  = {{16{r_c.p5[47]}}, r_c.p5};
        ua   = r_h[63] ? 64'(-r_h) : 64'(r_h);
        mop  = (r_ph == 2'd0) ? ua[31:0] : ua[63:32];
        prod = {32'd0, mop} * {32'd0, r_t};
        s    = (r_prod << 16) + (r_lo >> 16);
        if (r_prod >= 64'h4000_0000_0000) begin
            mr = HCAP;
        end else if (s > 64'(HCAP)) begin
            mr = HCAP;
        end else begin
            mr = $signed(s);
        end
        mt = r_h[63] ? -mr : mr;
        case (r_k)
            4'd0:    addend = p4w;
            4'd1:    addend = p3w;
            4'd5:    addend = p4w * 64'sd4;
            4'd6:    addend = p3w * 64'sd3;
            4'd9:    addend = p4w * 64'sd12;
            4'd10:   addend = p3w * 64'sd6;
            default: addend = 64'sd0;
        endcase
        sum = mt + addend;
        if (sum > HCAP) begin
            clamped = HCAP;
        end else if (sum < -HCAP) begin
            clamped = -HCAP;
        end else begin
            clamped = sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && !i_start && (r_ph == 2'd2) && (r_k == 4'd11);
            if (i_start) begin
                r_busy <= 1'b1;
                r_c    <= i_coef;
                r_t    <= i_time;
                r_h    <= {{16{i_coef.p5[47]}}, i_coef.p5};
                r_k    <= 4'd0;
                r_ph   <= 2'd0;
            end else if (r_busy) begin
                case (r_ph)
                    2'd0: begin
                        r_prod <= prod;
                        r_ph   <= 2'd1;
                    end
                    2'd1: begin
                        r_lo   <= r_prod;
                        r_prod <= prod;
                        r_ph   <= 2'd2;
                    end
                    default: begin
                        r_ph <= 2'd0;
                        r_k  <= r_k + 4'd1;
                        case (r_k)
                            4'd4: begin
                                o_res.pos <= f_q16(clamped, r_c.p0);
                                r_h       <= p5w * 64'sd5;
                            end
                            4'd8: begin
                                o_res.vel <= f_q16(clamped, 32'sd0);
                                r_h       <= p5w * 64'sd20;
                            end
                            4'd11: begin
                                o_res.acc <= f_q16(clamped, 32'sd0);
                                r_busy    <= 1'b0;
                            end
                            default: r_h <= clamped;
                        endcase
                    end
                endcase
            end
        end
    end
endmodule

// ===== sv/quintic_joint_trajectory.sv =====
// channel | direction | handshake              | payload
// in      | input     | i_in_valid / o_in_stall | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
//
// an accepted plan runs twelve 128-bit restoring divisions by the duration,
// one quotient bit a cycle, in the coefficient divider
// a sample reads each joint's coefficients from memory, then runs twelve
// multiply-by-t steps through one 32x32 multiplier
// reset clears the per-joint valid bits at once, so no clearing pass is needed
// an output stall holds the finished result in the output register; the
// block takes no new item until every result of the current one is loaded into it
module quintic_joint_trajectory #(
    parameter int JOINTS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  qjt_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output qjt_pkg::t_out_item  o_out_data
);
    import qjt_pkg::*;

    localparam int LANES = (JOINTS < 8) ? JOINTS : 8;
    localparam int AW    = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    t_state           r_state;
    t_state           n_state;
    t_in_item         r_item;
    logic [2:0]       r_j;
    logic [JOINTS-1:0] r_vld;
    logic             r_rdvld;
    logic [1:0]       r_status;
    t_out_item        r_out;
    logic             r_ovalid;

    logic             in_xfer;
    logic             out_free;
    logic             plan_bad;
    logic signed [32:0] diff;
    logic [32:0]      mag;
    logic             div_start;
    logic             div_done;
    logic signed [47:0] p3;
    logic signed [47:0] p4;
    logic signed [47:0] p5;
    logic             eval_start;
    logic             eval_done;
    t_eval_res        eval_res;
    t_coef            wcoef;
    t_coef            rcoef;
    t_coef            ecoef;
    logic             ram_we;
    logic             ram_re;
    logic [3:0]       widx;
    logic [3:0]       ridx;
    logic [AW-1:0]    waddr;
    logic [AW-1:0]    raddr;
    logic             load_plan;
    logic             load_sample;

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_ovalid || !i_out_stall;

    assign plan_bad = (i_in_data.move_duration == 32'd0)
                   || ({2'b00, i_in_data.joint_index} >= 5'(JOINTS));
    assign diff = {i_in_data.end_position[31], i_in_data.end_position}
                - {i_in_data.start_position[31], i_in_data.start_position};
    assign mag  = diff[32] ? 33'(-diff) : 33'(diff);

    assign widx  = {1'b0, r_item.joint_index};
    assign ridx  = {1'b0, r_j};
    assign waddr = widx[AW-1:0];
    assign raddr = ridx[AW-1:0];

    assign wcoef.p0 = r_item.start_position;
    assign wcoef.p3 = p3;
    assign wcoef.p4 = p4;
    assign wcoef.p5 = p5;
    assign ecoef    = r_rdvld ? rcoef : '0;

    qjt_ram #(
        .WIDTH(COEF_W),
        .DEPTH(JOINTS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(waddr),
        .i_wdata(wcoef),
        .i_re   (ram_re),
        .i_raddr(raddr),
        .o_rdata(rcoef)
    );

    qjt_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_mag  (mag),
        .i_neg  (diff[32]),
        .i_dur  (i_in_data.move_duration),
        .o_done (div_done),
        .o_p3   (p3),
        .o_p4   (p4),
        .o_p5   (p5)
    );

    qjt_eval u_eval (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(eval_start),
        .i_coef (ecoef),
        .i_time (r_item.sample_time),
        .o_done (eval_done),
        .o_res  (eval_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        div_start   = 1'b0;
        eval_start  = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load_plan   = 1'b0;
        load_sample = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_in_data.opcode == OP_SAMPLE) begin
                        n_state = S_RD;
                    end else if (plan_bad) begin
                        n_state = S_POUT;
                    end else begin
                        div_start = 1'b1;
                        n_state   = S_PDIV;
                    end
                end
            end
            S_PDIV: begin
                if (div_done) begin
                    n_state = S_PWR;
                end
            end
            S_PWR: begin
                ram_we  = 1'b1;
                n_state = S_POUT;
            end
            S_POUT: begin
                if (out_free) begin
                    load_plan = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            S_RD: begin
                ram_re  = 1'b1;
                n_state = S_LD;
            end
            S_LD: begin
                eval_start = 1'b1;
                n_state    = S_EVAL;
            end
            S_EVAL: begin
                if (eval_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    load_sample = 1'b1;
                    n_state     = (r_j == 3'(LANES - 1)) ? S_IDLE : S_RD;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_ovalid <= 1'b0;
            r_j      <= 3'd0;
        end else begin
            if (in_xfer) begin
                r_item   <= i_in_data;
                r_j      <= 3'd0;
                r_status <= plan_bad ? ST_PLAN_REJ : ST_PLAN_OK;
            end
            if (ram_we) begin
                r_vld[waddr] <= 1'b1;
            end
            if (ram_re) begin
                r_rdvld <= r_vld[raddr];
            end
            if (load_plan || load_sample) begin
                r_ovalid <= 1'b1;
            end else if (r_ovalid && !i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if (load_plan) begin
                r_out.out_joint    <= r_item.joint_index;
                r_out.position     <= 32'sd0;
                r_out.velocity     <= 32'sd0;
                r_out.acceleration <= 32'sd0;
                r_out.status       <= r_status;
                r_out.last         <= 1'b1;
            end
            if (load_sample) begin
                r_out.out_joint    <= r_j;
                r_out.position     <= eval_res.pos;
                r_out.velocity     <= eval_res.vel;
                r_out.acceleration <= eval_res.acc;
                r_out.status       <= ST_SAMPLE;
                r_out.last         <= (r_j == 3'(LANES - 1));
                r_j                <= r_j + 3'd1;
            end
        end
    end
endmodule
